// ----- rtl/core/lsd_pkg.sv -----
package lsd_pkg;

  localparam int SENSOR_COUNT_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int SAMPLE_W = 12;
  localparam int CAM_W    = 8;
  localparam int DIR_W    = 15;
  localparam int HITS_W   = 16;
  localparam int SUM_W    = 12;

  localparam int                  CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_OFFSET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_OFFSET = 1'd1;
  localparam logic [SAMPLE_W-1:0]  LOW_OFFSET_RST  = 12'd100;
  localparam logic [SAMPLE_W-1:0]  HIGH_OFFSET_RST = 12'd300;

  localparam logic signed [CAM_W-1:0] CAM_NO_TARGET = -8'sd128;

  // direction scale, and floor(2^24/127) for the camera fallback division
  localparam logic [13:0] DIR_SCALE   = 14'd10000;
  localparam logic [17:0] RECIP_127   = 18'd132104;
  localparam int          RECIP_SHIFT = 24;
  localparam logic [6:0]  CAM_FULL    = 7'd127;

  // pi in angle units where 2^31 is a half turn
  localparam logic signed [33:0] ANGLE_PI = 34'sd2147483648;

  localparam int UPC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SENSE_LO,
    OP_SENSE_HI,
    OP_CORDIC_INIT,
    OP_ROTATE,
    OP_ANG_MUL,
    OP_ANG_SCALE,
    OP_FB_MUL,
    OP_FB_RECIP,
    OP_FB_FIX,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_LAST,
    C_FALLBACK,
    C_ITER_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             fin;
  } uword_t;

  typedef struct packed {
    logic start_ok;
    logic last;
    logic fallback;
    logic iter_more;
    logic out_busy;
  } status_t;

  localparam logic [UPC_W-1:0] U_SENSE_LO = 4'd0;
  localparam logic [UPC_W-1:0] U_SENSE_HI = 4'd1;
  localparam logic [UPC_W-1:0] U_CHECK    = 4'd2;
  localparam logic [UPC_W-1:0] U_ROT      = 4'd3;
  localparam logic [UPC_W-1:0] U_ANG_MUL  = 4'd4;
  localparam logic [UPC_W-1:0] U_ANG_SCL  = 4'd5;
  localparam logic [UPC_W-1:0] U_FB_MUL   = 4'd6;
  localparam logic [UPC_W-1:0] U_FB_RECIP = 4'd7;
  localparam logic [UPC_W-1:0] U_FB_FIX   = 4'd8;
  localparam logic [UPC_W-1:0] U_EMIT     = 4'd9;

  // jump to target when cond holds, else stop if fin, else fall through
  function automatic uword_t ucode(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: U_SENSE_LO, fin: 1'b1};
    case (a)
      U_SENSE_LO: w = '{op: OP_SENSE_LO,    cond: C_NEVER,     target: U_SENSE_LO, fin: 1'b0};
      U_SENSE_HI: w = '{op: OP_SENSE_HI,    cond: C_LAST,      target: U_CHECK,    fin: 1'b1};
      U_CHECK:    w = '{op: OP_CORDIC_INIT, cond: C_FALLBACK,  target: U_FB_MUL,   fin: 1'b0};
      U_ROT:      w = '{op: OP_ROTATE,      cond: C_ITER_MORE, target: U_ROT,      fin: 1'b0};
      U_ANG_MUL:  w = '{op: OP_ANG_MUL,     cond: C_NEVER,     target: U_SENSE_LO, fin: 1'b0};
      U_ANG_SCL:  w = '{op: OP_ANG_SCALE,   cond: C_ALWAYS,    target: U_EMIT,     fin: 1'b0};
      U_FB_MUL:   w = '{op: OP_FB_MUL,      cond: C_NEVER,     target: U_SENSE_LO, fin: 1'b0};
      U_FB_RECIP: w = '{op: OP_FB_RECIP,    cond: C_NEVER,     target: U_SENSE_LO, fin: 1'b0};
      U_FB_FIX:   w = '{op: OP_FB_FIX,      cond: C_NEVER,     target: U_SENSE_LO, fin: 1'b0};
      U_EMIT:     w = '{op: OP_EMIT,        cond: C_OUT_BUSY,  target: U_EMIT,     fin: 1'b1};
      default:    w = '{op: OP_NOP,         cond: C_NEVER,     target: U_SENSE_LO, fin: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [SAMPLE_W-1:0] lim_of(input int k);
    logic [SAMPLE_W-1:0] v;
    case (k)
      0:       v = 12'd1400;
      1:       v = 12'd550;
      2:       v = 12'd500;
      3:       v = 12'd1000;
      4:       v = 12'd600;
      5:       v = 12'd550;
      6:       v = 12'd550;
      7:       v = 12'd500;
      8:       v = 12'd500;
      9:       v = 12'd750;
      10:      v = 12'd500;
      11:      v = 12'd500;
      12:      v = 12'd550;
      13:      v = 12'd500;
      14:      v = 12'd1000;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] wx_of(input int k);
    logic signed [7:0] v;
    case (k)
      1, 7:    v = -8'sd38;
      2, 6:    v = -8'sd71;
      3, 5:    v = -8'sd92;
      4:       v = -8'sd100;
      9, 15:   v = 8'sd38;
      10, 14:  v = 8'sd71;
      11, 13:  v = 8'sd92;
      12:      v = 8'sd100;
      default: v = 8'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] wy_of(input int k);
    logic signed [7:0] v;
    case (k)
      0:       v = 8'sd100;
      1, 15:   v = 8'sd92;
      2, 14:   v = 8'sd71;
      3, 13:   v = 8'sd38;
      5, 11:   v = -8'sd38;
      6, 10:   v = -8'sd71;
      7, 9:    v = -8'sd92;
      8:       v = -8'sd100;
      default: v = 8'sd0;
    endcase
    return v;
  endfunction

  // atan(2^-i) scaled so that 2^31 is pi
  function automatic logic [29:0] atan_of(input int i);
    logic [29:0] v;
    case (i)
      0:       v = 30'd536870912;
      1:       v = 30'd316933406;
      2:       v = 30'd167458907;
      3:       v = 30'd85004756;
      4:       v = 30'd42667331;
      5:       v = 30'd21354465;
      6:       v = 30'd10679838;
      7:       v = 30'd5340245;
      8:       v = 30'd2670163;
      9:       v = 30'd1335087;
      10:      v = 30'd667544;
      11:      v = 30'd333772;
      12:      v = 30'd166886;
      13:      v = 30'd83443;
      14:      v = 30'd41722;
      15:      v = 30'd20861;
      16:      v = 30'd10430;
      17:      v = 30'd5215;
      18:      v = 30'd2608;
      19:      v = 30'd1304;
      20:      v = 30'd652;
      21:      v = 30'd326;
      22:      v = 30'd163;
      23:      v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/line_sensor_direction_top.sv -----
// channel | dir | handshake           | payload
// --------+-----+---------------------+---------------------------------------------
// in      | in  | in_valid / in_stall   | mux_position, sample_low, sample_high,
//         |     |                     | camera_value
// out     | out | out_valid / out_stall | direction, used_fallback, hit_bits
// cfg     | in  | cfg_we (no wait)    | cfg_index, cfg_data
//
// A word that is ignored (position out of range, or scan not running) starts no microprogram.
// A sensed word runs the low and high sense steps; the last word of a scan then
// runs the CORDIC init and rotate loop, angle multiply and scale, and emit, or with
// the camera fallback the fallback multiply, reciprocal, fix and emit steps.
// Reset is synchronous: scan state and out_valid clear; the offsets load their reset values.
// in_stall is high while the microprogram runs; an out_stall holds it on its emit step.
module line_sensor_direction_top #(
  parameter int SENSOR_COUNT = lsd_pkg::SENSOR_COUNT_DEF,
  parameter int CORDIC_STEPS = lsd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          mux_position,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        sample_low,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        sample_high,
  input  logic signed [lsd_pkg::CAM_W-1:0]    camera_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lsd_pkg::DIR_W-1:0]    direction,
  output logic                                used_fallback,
  output logic [lsd_pkg::HITS_W-1:0]          hit_bits,
  input  logic                                cfg_we,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        cfg_data
);
  import lsd_pkg::*;

  logic [SAMPLE_W-1:0] low_offset, high_offset;
  logic                accept, start, seq_busy;
  op_t                 dp_op;
  status_t             dp_status;

  assign in_stall = seq_busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && dp_status.start_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_offset  <= LOW_OFFSET_RST;
      high_offset <= HIGH_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_OFFSET:  low_offset  <= cfg_data;
        REG_HIGH_OFFSET: high_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lsd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .op     (dp_op),
    .busy   (seq_busy)
  );

  lsd_datapath #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .op            (dp_op),
    .mux_position  (mux_position),
    .sample_low    (sample_low),
    .sample_high   (sample_high),
    .camera_value  (camera_value),
    .low_offset    (low_offset),
    .high_offset   (high_offset),
    .out_stall     (out_stall),
    .status        (dp_status),
    .out_valid     (out_valid),
    .direction     (direction),
    .used_fallback (used_fallback),
    .hit_bits      (hit_bits)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("sequencer did not start on a sensed word");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(dp_op == OP_EMIT))
    else $error("output loaded outside the emit step");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (dp_op == OP_EMIT) && !dp_status.out_busy |=> out_valid && !in_stall)
    else $error("emit step did not finish the program");

endmodule

// ----- rtl/core/lsd_sequencer.sv -----
module lsd_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lsd_pkg::status_t status,
  output lsd_pkg::op_t     op,
  output logic             busy
);
  import lsd_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state, state_next;
  logic [UPC_W-1:0] upc, upc_next;
  uword_t           word;
  logic             taken;

  assign word = ucode(upc);
  assign busy = (state == SEQ_RUN);
  assign op   = busy ? word.op : OP_NOP;

  always_comb begin
    case (word.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_LAST:      taken = status.last;
      C_FALLBACK:  taken = status.fallback;
      C_ITER_MORE: taken = status.iter_more;
      C_OUT_BUSY:  taken = status.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    upc_next   = upc;
    case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
          upc_next   = U_SENSE_LO;
        end
      end
      SEQ_RUN: begin
        if (taken) begin
          upc_next = word.target;
        end else if (word.fin) begin
          state_next = SEQ_IDLE;
        end else begin
          upc_next = upc + 1'b1;
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= U_SENSE_LO;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

endmodule

// ----- rtl/core/lsd_datapath.sv -----
module lsd_datapath #(
  parameter int SENSOR_COUNT = lsd_pkg::SENSOR_COUNT_DEF,
  parameter int CORDIC_STEPS = lsd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  lsd_pkg::op_t                        op,
  input  logic [2:0]                          mux_position,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        sample_low,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        sample_high,
  input  logic signed [lsd_pkg::CAM_W-1:0]    camera_value,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        low_offset,
  input  logic [lsd_pkg::SAMPLE_W-1:0]        high_offset,
  input  logic                                out_stall,
  output lsd_pkg::status_t                    status,
  output logic                                out_valid,
  output logic signed [lsd_pkg::DIR_W-1:0]    direction,
  output logic                                used_fallback,
  output logic [lsd_pkg::HITS_W-1:0]          hit_bits
);
  import lsd_pkg::*;

  localparam int HALF = SENSOR_COUNT / 2;
  localparam int SW   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int IW   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // captured item
  logic [2:0]                 pos;
  logic [SAMPLE_W-1:0]        s_lo, s_hi;
  logic signed [CAM_W-1:0]    cam;

  // scan state
  logic signed [SUM_W-1:0]    x_sum, y_sum;
  logic [SENSOR_COUNT-1:0]    hit_mask;
  logic                       scan_enabled;

  // arithmetic registers
  logic signed [31:0]         re, im;
  logic signed [33:0]         z;
  logic [IW-1:0]              iter;
  logic [45:0]                prod;
  logic [DIR_W-1:0]           quo;
  logic                       neg;
  logic                       fb;

  // sensing
  logic                       sense_hi;
  logic [SW-1:0]              k;
  logic [SAMPLE_W-1:0]        sample, offset;
  logic [SAMPLE_W:0]          limit;
  logic                       hit, old;
  logic signed [SUM_W-1:0]    wx, wy;

  // cordic / scaling
  logic signed [31:0]         re_sh, im_sh, y_fix, x_fix;
  logic signed [33:0]         t_step, z_abs;
  logic [CAM_W-1:0]           cam_abs;
  logic [38:0]                rec;
  logic [21:0]                rem;
  logic [31:0]                mask_wide;

  assign sense_hi = (op == OP_SENSE_HI);
  assign k        = sense_hi ? SW'(pos) + SW'(HALF) : SW'(pos);
  assign sample   = sense_hi ? s_hi : s_lo;
  assign offset   = sense_hi ? high_offset : low_offset;
  assign limit    = {1'b0, lim_of(int'(k))} + {1'b0, offset};
  assign hit      = {1'b0, sample} < limit;
  assign old      = hit_mask[k];
  assign wx       = SUM_W'(wx_of(int'(k)));
  assign wy       = SUM_W'(wy_of(int'(k)));

  assign y_fix  = {{4{y_sum[SUM_W-1]}}, y_sum, 16'b0};
  assign x_fix  = {{4{x_sum[SUM_W-1]}}, x_sum, 16'b0};
  assign re_sh  = re >>> iter;
  assign im_sh  = im >>> iter;
  assign t_step = $signed({4'b0, atan_of(int'(iter))});
  assign z_abs  = z[33] ? -z : z;
  assign cam_abs = cam[CAM_W-1] ? -cam : cam;
  assign rec    = 39'(prod[20:0]) * 39'(RECIP_127);
  // remainder of n - 127*q
  assign rem    = prod[21:0] - (22'({quo, 7'b0}) - 22'(quo));
  assign mask_wide = 32'(hit_mask);

  assign status.start_ok  = (int'(mux_position) < HALF) &&
                            ((mux_position == 3'd0) ? (camera_value == CAM_NO_TARGET)
                                                    : scan_enabled);
  assign status.last      = (int'(pos) == HALF - 1);
  assign status.fallback  = (x_sum == '0) && (y_sum == '0);
  assign status.iter_more = (iter != IW'(CORDIC_STEPS - 1));
  assign status.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enabled <= 1'b0;
      x_sum        <= '0;
      y_sum        <= '0;
      hit_mask     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // the emit step reloads the word itself
      if (out_valid && !out_stall && (op != OP_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        pos  <= mux_position;
        s_lo <= sample_low;
        s_hi <= sample_high;
        cam  <= camera_value;
        if (mux_position == 3'd0) begin
          x_sum        <= '0;
          y_sum        <= '0;
          hit_mask     <= '0;
          scan_enabled <= (camera_value == CAM_NO_TARGET);
        end
      end
      case (op)
        OP_SENSE_LO, OP_SENSE_HI: begin
          if (hit && !old) begin
            hit_mask[k] <= 1'b1;
            x_sum       <= x_sum + wx;
            y_sum       <= y_sum + wy;
          end else if (!hit && old) begin
            hit_mask[k] <= 1'b0;
            x_sum       <= x_sum - wx;
            y_sum       <= y_sum - wy;
          end
        end
        OP_CORDIC_INIT: begin
          iter <= '0;
          if (y_sum[SUM_W-1]) begin
            re <= -y_fix;
            im <= -x_fix;
            z  <= x_sum[SUM_W-1] ? -ANGLE_PI : ANGLE_PI;
          end else begin
            re <= y_fix;
            im <= x_fix;
            z  <= '0;
          end
        end
        OP_ROTATE: begin
          iter <= iter + 1'b1;
          if (!im[31]) begin
            re <= re + im_sh;
            im <= im - re_sh;
            z  <= z + t_step;
          end else begin
            re <= re - im_sh;
            im <= im + re_sh;
            z  <= z - t_step;
          end
        end
        OP_ANG_MUL: begin
          prod <= 46'(z_abs[31:0]) * 46'(DIR_SCALE);
          neg  <= z[33];
          fb   <= 1'b0;
        end
        OP_ANG_SCALE: begin
          quo <= prod[45:31];
        end
        OP_FB_MUL: begin
          prod <= 46'(cam_abs) * 46'(DIR_SCALE);
          neg  <= cam[CAM_W-1];
          fb   <= 1'b1;
        end
        OP_FB_RECIP: begin
          quo <= rec[RECIP_SHIFT +: DIR_W];
        end
        OP_FB_FIX: begin
          if (rem >= 22'(CAM_FULL)) begin
            quo <= quo + 1'b1;
          end
        end
        OP_EMIT: begin
          if (!status.out_busy) begin
            out_valid     <= 1'b1;
            direction     <= neg ? -$signed(quo) : $signed(quo);
            used_fallback <= fb;
            hit_bits      <= mask_wide[HITS_W-1:0];
            scan_enabled  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
